### rtl/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants for the single-precision multiplier
// Holds the operand and result structures and the format constants.
// ----------------------------------------------------------------------------
package sfm_pkg;

    localparam int EXP_BITS  = 8;
    localparam int FRAC_BITS = 23;
    localparam int SIG_BITS  = FRAC_BITS + 1;
    localparam int WORD_BITS = 1 + EXP_BITS + FRAC_BITS;
    // Each cell folds this many multiplier bits into the partial product.
    localparam int DIGIT_BITS = 6;
    localparam int NUM_CELLS  = SIG_BITS / DIGIT_BITS;
    localparam int PROD_BITS  = 2 * SIG_BITS;
    localparam int EXPW       = EXP_BITS + 2;
    localparam logic [EXPW-1:0] EXP_BIAS = EXPW'(127);
    localparam logic [EXPW-1:0] EXP_MAX  = EXPW'(254);

    typedef struct packed {
        logic [WORD_BITS-1:0] operand_a;
        logic [WORD_BITS-1:0] operand_b;
    } sfm_in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] product_bits;
        logic                 overflowed;
        logic                 underflowed;
    } sfm_out_t;

    // Work carried from one cell to the next.
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic                 sign;
        logic [EXPW-1:0]      exp_sum;
        logic [SIG_BITS-1:0]  mcand;
        logic [SIG_BITS-1:0]  mplier;
        logic [PROD_BITS-1:0] acc;
    } sfm_work_t;

endpackage

### rtl/single_float_multiply.sv
// ----------------------------------------------------------------------------
// single_float_multiply: truncating IEEE single-precision multiplier
// Pipeline: four multiply cells, each folding six multiplier bits into the
// product, then one output stage. Throughput: one transfer per cycle while
// the output register is not full and stalled.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module single_float_multiply (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  sfm_pkg::sfm_in_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output sfm_pkg::sfm_out_t out_data
);
    import sfm_pkg::*;

    // The whole chain moves together; it halts only when the output
    // register holds a result that cannot leave this cycle.
    logic      advance;
    sfm_work_t head;
    sfm_work_t link [NUM_CELLS+1];
    logic [EXP_BITS-1:0] ea;
    logic [EXP_BITS-1:0] eb;

    logic      out_valid_reg;
    sfm_out_t  out_data_reg;
    sfm_out_t  out_data_next;
    sfm_work_t tail;
    logic          norm;
    logic [EXPW-1:0]  exp_fin;
    logic [FRAC_BITS-1:0] frac;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // Unpack the operands and prepare the exponent sum ahead of the chain.
    always_comb
    begin
        ea = in_data.operand_a[FRAC_BITS +: EXP_BITS];
        eb = in_data.operand_b[FRAC_BITS +: EXP_BITS];
        head.valid   = in_valid;
        head.zero    = (ea == '0) || (eb == '0);
        head.sign    = in_data.operand_a[WORD_BITS-1] ^ in_data.operand_b[WORD_BITS-1];
        head.exp_sum = EXPW'(ea) + EXPW'(eb);
        head.mcand   = {1'b1, in_data.operand_a[FRAC_BITS-1:0]};
        head.mplier  = {1'b1, in_data.operand_b[FRAC_BITS-1:0]};
        head.acc     = '0;
    end

    assign link[0] = head;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            sfm_cell #(.STEP(g)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .work_in  (link[g]),
                .work_out (link[g+1])
            );
        end
    endgenerate

    assign tail = link[NUM_CELLS];

    // Normalise by one place when the product reached 2.0, then saturate
    // or flush on exponent range. The exponent sum is at most 510 and the
    // bias is subtracted after the compare against 127, so no sign is needed.
    always_comb
    begin
        norm    = tail.acc[PROD_BITS-1];
        exp_fin = tail.exp_sum + EXPW'(norm) - EXP_BIAS;
        frac    = norm ? tail.acc[FRAC_BITS+1 +: FRAC_BITS]
                       : tail.acc[FRAC_BITS +: FRAC_BITS];
        out_data_next = '0;
        if (tail.zero)
        begin
            out_data_next = '0;
        end
        else if (tail.exp_sum + EXPW'(norm) <= EXP_BIAS)
        begin
            out_data_next.product_bits = {tail.sign, {(WORD_BITS-1){1'b0}}};
            out_data_next.underflowed  = 1'b1;
        end
        else if (exp_fin > EXP_MAX)
        begin
            out_data_next.product_bits = {tail.sign, {EXP_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
            out_data_next.overflowed   = 1'b1;
        end
        else
        begin
            out_data_next.product_bits = {tail.sign, exp_fin[EXP_BITS-1:0], frac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A held result must not change while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid_reg && out_stall) |-> $stable(out_data_reg))
        else $error("result changed while stalled");

    // Overflow and underflow never occur together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.overflowed && out_data_reg.underflowed))
        else $error("both range flags set");

    // The input is stalled only when the output is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without cause");

endmodule

### rtl/sfm_cell.sv
// ----------------------------------------------------------------------------
// sfm_cell: one cell of the multiplier chain
// Adds one digit of partial products into the accumulator and hands on.
// ----------------------------------------------------------------------------
module sfm_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sfm_pkg::sfm_work_t work_in,
    output sfm_pkg::sfm_work_t work_out
);
    import sfm_pkg::*;

    localparam int SHIFT     = STEP * DIGIT_BITS;
    localparam int PART_BITS = SIG_BITS + DIGIT_BITS;

    logic                  valid_reg;
    sfm_work_t             work_reg;
    sfm_work_t             work_next;
    logic [DIGIT_BITS-1:0] digit;
    logic [PART_BITS-1:0]  part;

    always_comb
    begin
        digit     = work_in.mplier[SHIFT +: DIGIT_BITS];
        part      = PART_BITS'(work_in.mcand) * PART_BITS'(digit);
        work_next = work_in;
        work_next.acc = work_in.acc + (PROD_BITS'(part) << SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= work_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

    always_comb
    begin
        work_out       = work_reg;
        work_out.valid = valid_reg;
    end

endmodule
